>>> sv/owqadc_pkg.sv
`timescale 1ns / 1ps
package owqadc_pkg;

  localparam int MEM_BYTES_DEF = 32;
  localparam int CHANNELS_DEF  = 4;
  localparam int PAGE_BYTES    = 8;
  localparam int PAGE_AW       = $clog2(PAGE_BYTES);

  localparam logic [2:0] REQ_BUS_RESET   = 3'd0;
  localparam logic [2:0] REQ_MASTER_BYTE = 3'd1;
  localparam logic [2:0] REQ_READ_SLOT   = 3'd2;
  localparam logic [2:0] REQ_HOST_SET    = 3'd3;
  localparam logic [2:0] REQ_HOST_READ   = 3'd4;

  localparam logic [7:0] CMD_READ    = 8'hAA;
  localparam logic [7:0] CMD_WRITE   = 8'h55;
  localparam logic [7:0] CMD_CONVERT = 8'h3C;

  localparam logic [7:0] MASK_CTRL_LO = 8'b11001111;
  localparam logic [7:0] MASK_CTRL_HI = 8'b10111101;
  localparam logic [7:0] DEF_CTRL_HI  = 8'h8C;
  localparam logic [7:0] DEF_ALARM_HI = 8'hFF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  typedef enum logic [3:0] {
    PH_CMD,
    PH_ADDR,
    PH_RD_DATA,
    PH_RD_CRC,
    PH_WR_DATA,
    PH_WR_CRC,
    PH_WR_ECHO,
    PH_CV_CRC,
    PH_CV_BIT,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    TX_NONE,
    TX_MEM,
    TX_CRC_LO,
    TX_CRC_HI,
    TX_DATA,
    TX_BIT
  } tx_sel_t;

  typedef enum logic [2:0] {
    CRC_KEEP,
    CRC_START,
    CRC_RX,
    CRC_MEM,
    CRC_CLEAR,
    CRC_LOAD
  } crc_op_t;

  // what the read stage needs to finish one beat
  typedef struct packed {
    tx_sel_t     tx_sel;
    crc_op_t     crc_op;
    logic [1:0]  status;
    logic [7:0]  data;
    logic [15:0] crc_load;
    logic        odd_sel;
    logic        in_range;
    logic        host_rd;
    logic        vld_even;
    logic        vld_odd;
    logic [7:0]  byte_base;
  } s1_side_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  // power-on contents of the byte memory
  function automatic logic [7:0] mem_default(input logic [7:0] a, input int unsigned channels);
    logic [7:0] off1;
    logic [7:0] off2;
    logic [7:0] res;
    off1 = a - 8'(PAGE_BYTES);
    off2 = a - 8'(2 * PAGE_BYTES);
    res = 8'h00;
    if (a >= 8'(PAGE_BYTES) && a < 8'(2 * PAGE_BYTES) && off1[0] &&
        32'(off1[7:1]) < channels) begin
      res = DEF_CTRL_HI;
    end
    if (a >= 8'(2 * PAGE_BYTES) && a < 8'(3 * PAGE_BYTES) && off2[0] &&
        32'(off2[7:1]) < channels) begin
      res = DEF_ALARM_HI;
    end
    return res;
  endfunction

  // control byte masks of page 1
  function automatic logic [7:0] ctrl_mask(input logic [7:0] a, input int unsigned channels);
    logic [7:0] off1;
    logic [7:0] res;
    off1 = a - 8'(PAGE_BYTES);
    res = 8'hFF;
    if (a >= 8'(PAGE_BYTES) && a < 8'(2 * PAGE_BYTES) && 32'(off1[7:1]) < channels) begin
      res = off1[0] ? MASK_CTRL_HI : MASK_CTRL_LO;
    end
    return res;
  endfunction

endpackage

>>> sv/owqadc_ram.sv
`timescale 1ns / 1ps
module owqadc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/owqadc_resp.sv
`timescale 1ns / 1ps
module owqadc_resp #(
  parameter int CHANNELS = owqadc_pkg::CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  owqadc_pkg::s1_side_t side,
  input  logic [7:0]           even_rdata,
  input  logic [7:0]           odd_rdata,
  output logic                 hold,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_tx_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_tx_is_bit,
  output logic [1:0]           out_status,
  output logic [15:0]          out_channel_value
);
  import owqadc_pkg::*;

  logic        v1_r;
  s1_side_t    side_r;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic        adv;
  logic [7:0]  even_b;
  logic [7:0]  odd_b;
  logic [7:0]  mem_b;
  logic [15:0] inv;
  logic        txv;
  logic [7:0]  tx;
  logic        tx_bit;
  logic [15:0] chv;

  logic        out_valid_r;
  logic        tx_valid_r;
  logic [7:0]  tx_byte_r;
  logic        tx_is_bit_r;
  logic [1:0]  status_r;
  logic [15:0] chv_r;

  assign adv  = v1_r && (!out_valid_r || !out_stall);
  assign hold = v1_r && !adv;

  // entries never written read as their power-on value
  assign even_b = side_r.vld_even ? even_rdata : mem_default(side_r.byte_base, CHANNELS);
  assign odd_b  = side_r.vld_odd ? odd_rdata :
                  mem_default({side_r.byte_base[7:1], 1'b1}, CHANNELS);
  assign mem_b  = !side_r.in_range ? 8'h00 : (side_r.odd_sel ? odd_b : even_b);
  assign inv    = ~crc_r;
  assign chv    = side_r.host_rd ? {odd_b, even_b} : 16'h0000;

  always_comb begin
    txv    = 1'b1;
    tx     = 8'h00;
    tx_bit = 1'b0;
    case (side_r.tx_sel)
      TX_NONE:   txv = 1'b0;
      TX_MEM:    tx = mem_b;
      TX_CRC_LO: tx = inv[7:0];
      TX_CRC_HI: tx = inv[15:8];
      TX_DATA:   tx = side_r.data;
      TX_BIT:    tx_bit = 1'b1;
      default:   txv = 1'b0;
    endcase
  end

  always_comb begin
    case (side_r.crc_op)
      CRC_KEEP:  crc_nxt = crc_r;
      CRC_START: crc_nxt = crc16_byte(16'h0000, side_r.data);
      CRC_RX:    crc_nxt = crc16_byte(crc_r, side_r.data);
      CRC_MEM:   crc_nxt = crc16_byte(crc_r, mem_b);
      CRC_CLEAR: crc_nxt = 16'h0000;
      CRC_LOAD:  crc_nxt = side_r.crc_load;
      default:   crc_nxt = crc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      crc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= load || hold;
      out_valid_r <= adv || (out_valid_r && out_stall);
      if (adv) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      side_r <= side;
    end
    if (adv) begin
      tx_valid_r  <= txv;
      tx_byte_r   <= tx;
      tx_is_bit_r <= tx_bit;
      status_r    <= side_r.status;
      chv_r       <= chv;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_valid      = tx_valid_r;
  assign out_tx_byte       = tx_byte_r;
  assign out_tx_is_bit     = tx_is_bit_r;
  assign out_status        = status_r;
  assign out_channel_value = chv_r;

endmodule

>>> sv/one_wire_quad_adc_memory_slave.sv
`timescale 1ns / 1ps
// channel  ports                                   beat
// in       in_valid, in_stall, in_req_type,        one bus byte, read slot, reset or
//          in_rx_byte, in_channel, in_value        host channel access
// out      out_valid, out_stall, out_tx_valid,     one response per input beat
//          out_tx_byte, out_tx_is_bit, out_status,
//          out_channel_value
//
// one beat per cycle while in_stall is low; the byte memory is read at the accept edge,
// and the output register loads from the ram read stage when out_stall lets it advance.
// rst_n is synchronous; memory defaults come from one valid bit per byte, so the block
// is ready in the cycle after reset.
// out_stall holds the output register; in_stall rises only when the output register and
// the ram read stage are both full.
module one_wire_quad_adc_memory_slave #(
  parameter int MEM_BYTES = owqadc_pkg::MEM_BYTES_DEF,
  parameter int CHANNELS  = owqadc_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic [1:0]  in_channel,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_is_bit,
  output logic [1:0]  out_status,
  output logic [15:0] out_channel_value
);
  import owqadc_pkg::*;

  localparam int WORDS = (MEM_BYTES + 1) / 2;
  localparam int WAW   = $clog2(WORDS);

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [7:0]  command_r;
  logic [7:0]  command_nxt;
  logic [15:0] addr_r;
  logic [15:0] addr_nxt;
  logic        cnt_r;
  logic        cnt_nxt;
  logic [7:0]  held_r;
  logic [7:0]  held_nxt;

  logic        vld_even_r [WORDS];
  logic        vld_odd_r [WORDS];

  logic           in_accept;
  logic           hold;
  logic [15:0]    addr_inc;
  logic [15:0]    addr_full;
  logic           addr_in_range;
  logic           wr_ok;
  logic           ch_ok;
  logic [WAW-1:0] rd_idx;
  logic           rd_ok;
  logic [7:0]     held_masked;
  logic           ram_re;
  logic           we_even;
  logic           we_odd;
  logic [WAW-1:0] ram_waddr;
  logic [7:0]     wdata_even;
  logic [7:0]     wdata_odd;
  logic           ram_we_even;
  logic           ram_we_odd;
  logic           ram_re_a;
  logic [7:0]     even_rdata;
  logic [7:0]     odd_rdata;
  s1_side_t       side;

  assign in_stall      = hold;
  assign in_accept     = in_valid && !in_stall;
  assign addr_inc      = addr_r + 16'd1;
  assign addr_full     = {in_rx_byte, addr_r[7:0]};
  assign addr_in_range = addr_r < 16'(MEM_BYTES);
  assign wr_ok         = addr_in_range && addr_r >= 16'(PAGE_BYTES);
  assign ch_ok         = 32'(in_channel) < CHANNELS;
  assign rd_idx        = (in_req_type == REQ_HOST_READ) ? WAW'(in_channel) : addr_r[WAW:1];
  assign rd_ok         = (in_req_type == REQ_HOST_READ) || addr_in_range;
  assign held_masked   = held_r & ctrl_mask(addr_r[7:0], CHANNELS);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (in_req_type)
      REQ_BUS_RESET: phase_nxt = PH_CMD;
      REQ_MASTER_BYTE: begin
        case (phase_r)
          PH_CMD: phase_nxt = PH_ADDR;
          PH_ADDR: begin
            if (cnt_r) begin
              if (command_r == CMD_READ) begin
                phase_nxt = (addr_full < 16'(MEM_BYTES)) ? PH_RD_DATA : PH_DONE;
              end else if (command_r == CMD_WRITE) begin
                phase_nxt = (addr_full < 16'(MEM_BYTES)) ? PH_WR_DATA : PH_DONE;
              end else if (command_r == CMD_CONVERT) begin
                phase_nxt = PH_CV_CRC;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_WR_DATA: phase_nxt = PH_WR_CRC;
          default: phase_nxt = phase_r;
        endcase
      end
      REQ_READ_SLOT: begin
        case (phase_r)
          PH_RD_DATA: begin
            if (addr_inc[PAGE_AW-1:0] == '0) begin
              phase_nxt = PH_RD_CRC;
            end
          end
          PH_RD_CRC: begin
            if (cnt_r) begin
              phase_nxt = addr_in_range ? PH_RD_DATA : PH_DONE;
            end
          end
          PH_WR_CRC: begin
            if (cnt_r) begin
              phase_nxt = PH_WR_ECHO;
            end
          end
          PH_CV_CRC: begin
            if (cnt_r) begin
              phase_nxt = PH_CV_BIT;
            end
          end
          PH_WR_ECHO: phase_nxt = (addr_inc < 16'(MEM_BYTES)) ? PH_WR_DATA : PH_DONE;
          PH_CV_BIT:  phase_nxt = PH_DONE;
          default:    phase_nxt = phase_r;
        endcase
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // datapath, memory access and read-stage sideband
  always_comb begin
    command_nxt    = command_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    held_nxt       = held_r;
    ram_re         = 1'b0;
    we_even        = 1'b0;
    we_odd         = 1'b0;
    ram_waddr      = addr_r[WAW:1];
    wdata_even     = held_masked;
    wdata_odd      = held_masked;
    side.tx_sel    = TX_NONE;
    side.crc_op    = CRC_KEEP;
    side.status    = ST_OK;
    side.data      = in_rx_byte;
    side.crc_load  = addr_inc;
    side.odd_sel   = addr_r[0];
    side.in_range  = addr_in_range;
    side.host_rd   = 1'b0;
    side.vld_even  = rd_ok && vld_even_r[rd_idx];
    side.vld_odd   = rd_ok && vld_odd_r[rd_idx];
    side.byte_base = 8'({rd_idx, 1'b0});
    case (in_req_type)
      REQ_BUS_RESET: cnt_nxt = 1'b0;
      REQ_MASTER_BYTE: begin
        case (phase_r)
          PH_CMD: begin
            command_nxt = in_rx_byte;
            side.crc_op = CRC_START;
            cnt_nxt     = 1'b0;
          end
          PH_ADDR: begin
            side.crc_op = CRC_RX;
            if (!cnt_r) begin
              addr_nxt = {8'h00, in_rx_byte};
              cnt_nxt  = 1'b1;
            end else begin
              addr_nxt = addr_full;
              cnt_nxt  = 1'b0;
              if (command_r != CMD_READ && command_r != CMD_WRITE &&
                  command_r != CMD_CONVERT) begin
                side.status = ST_UNKNOWN;
              end
            end
          end
          PH_WR_DATA: begin
            held_nxt    = in_rx_byte;
            side.crc_op = CRC_RX;
            cnt_nxt     = 1'b0;
          end
          default: side.status = ST_REJECT;
        endcase
      end
      REQ_READ_SLOT: begin
        case (phase_r)
          PH_RD_DATA: begin
            side.tx_sel = TX_MEM;
            side.crc_op = CRC_MEM;
            ram_re      = 1'b1;
            addr_nxt    = addr_inc;
            if (addr_inc[PAGE_AW-1:0] == '0) begin
              cnt_nxt = 1'b0;
            end
          end
          PH_RD_CRC, PH_WR_CRC, PH_CV_CRC: begin
            side.tx_sel = cnt_r ? TX_CRC_HI : TX_CRC_LO;
            cnt_nxt     = !cnt_r;
            // a page's crc restarts once its high byte has gone out
            if (cnt_r && phase_r == PH_RD_CRC) begin
              side.crc_op = CRC_CLEAR;
            end
          end
          PH_WR_ECHO: begin
            side.tx_sel = TX_DATA;
            side.data   = held_r;
            side.crc_op = CRC_LOAD;
            addr_nxt    = addr_inc;
            if (wr_ok) begin
              we_even = !addr_r[0];
              we_odd  = addr_r[0];
            end
          end
          PH_CV_BIT: side.tx_sel = TX_BIT;
          default:   side.status = ST_REJECT;
        endcase
      end
      REQ_HOST_SET: begin
        if (ch_ok) begin
          we_even    = 1'b1;
          we_odd     = 1'b1;
          ram_waddr  = WAW'(in_channel);
          wdata_even = in_value[7:0];
          wdata_odd  = in_value[15:8];
        end else begin
          side.status = ST_REJECT;
        end
      end
      REQ_HOST_READ: begin
        if (ch_ok) begin
          ram_re       = 1'b1;
          side.host_rd = 1'b1;
        end else begin
          side.status = ST_REJECT;
        end
      end
      default: side.status = ST_REJECT;
    endcase
  end

  assign ram_we_even = in_accept && we_even;
  assign ram_we_odd  = in_accept && we_odd;
  assign ram_re_a    = in_accept && ram_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CMD;
      command_r <= 8'h00;
      addr_r    <= 16'h0000;
      cnt_r     <= 1'b0;
      held_r    <= 8'h00;
      for (int i = 0; i < WORDS; i++) begin
        vld_even_r[i] <= 1'b0;
        vld_odd_r[i]  <= 1'b0;
      end
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      command_r <= command_nxt;
      addr_r    <= addr_nxt;
      cnt_r     <= cnt_nxt;
      held_r    <= held_nxt;
      if (we_even) begin
        vld_even_r[ram_waddr] <= 1'b1;
      end
      if (we_odd) begin
        vld_odd_r[ram_waddr] <= 1'b1;
      end
    end
  end

  owqadc_ram #(
    .WIDTH (8),
    .DEPTH (WORDS)
  ) u_ram_even (
    .clk   (clk),
    .we    (ram_we_even),
    .waddr (ram_waddr),
    .wdata (wdata_even),
    .re    (ram_re_a),
    .raddr (rd_idx),
    .rdata (even_rdata)
  );

  owqadc_ram #(
    .WIDTH (8),
    .DEPTH (WORDS)
  ) u_ram_odd (
    .clk   (clk),
    .we    (ram_we_odd),
    .waddr (ram_waddr),
    .wdata (wdata_odd),
    .re    (ram_re_a),
    .raddr (rd_idx),
    .rdata (odd_rdata)
  );

  owqadc_resp #(
    .CHANNELS (CHANNELS)
  ) u_resp (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (in_accept),
    .side              (side),
    .even_rdata        (even_rdata),
    .odd_rdata         (odd_rdata),
    .hold              (hold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_tx_is_bit     (out_tx_is_bit),
    .out_status        (out_status),
    .out_channel_value (out_channel_value)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import owqadc_pkg::*;

  localparam int MEMB        = MEM_BYTES_DEF;
  localparam int CHN         = CHANNELS_DEF;
  localparam int RAND_ITEMS  = 800;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_is_bit;
    logic [1:0]  status;
    logic [15:0] chan_val;
  } reply_t;

  typedef struct {
    logic [2:0]  req;
    logic [7:0]  rx;
    logic [1:0]  ch;
    logic [15:0] val;
    bit          known;
    reply_t      want;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [1:0]  in_channel = '0;
  logic [15:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_tx_is_bit;
  logic [1:0]  out_status;
  logic [15:0] out_channel_value;

  one_wire_quad_adc_memory_slave u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .in_channel       (in_channel),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_tx_is_bit    (out_tx_is_bit),
    .out_status       (out_status),
    .out_channel_value(out_channel_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // slave state as the checker sees it
  logic [7:0]  m_mem [MEMB];
  logic [7:0]  m_cmd;
  logic [15:0] m_addr;
  phase_t      m_phase;
  logic [15:0] m_crc;
  bit          m_second;
  logic [7:0]  m_held;

  reply_t      replies_due[$];
  stim_row_t   directed_rows[$];
  int          n_mismatch;
  int          n_checked;
  int          n_items;
  int          burst_left;
  int          cycle_count;
  int          stall_mode;
  int          stall_timer;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    repeat (8) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    return x;
  endfunction

  function automatic reply_t mk_reply(input logic txv, input logic [7:0] tx, input logic bitr,
                                      input logic [1:0] st, input logic [15:0] chv);
    reply_t r;
    r.tx_valid  = txv;
    r.tx_byte   = tx;
    r.tx_is_bit = bitr;
    r.status    = st;
    r.chan_val  = chv;
    return r;
  endfunction

  task automatic mask_ctrl_page();
    for (int k = 0; k < CHN; k++) begin
      m_mem[PAGE_BYTES + 2 * k]     &= MASK_CTRL_LO;
      m_mem[PAGE_BYTES + 2 * k + 1] &= MASK_CTRL_HI;
    end
  endtask

  task automatic slave_reset();
    for (int i = 0; i < MEMB; i++) m_mem[i] = 8'h00;
    for (int k = 0; k < CHN; k++) begin
      m_mem[PAGE_BYTES + 2 * k + 1]     = DEF_CTRL_HI;
      m_mem[2 * PAGE_BYTES + 2 * k + 1] = DEF_ALARM_HI;
    end
    m_cmd    = 8'h00;
    m_addr   = 16'h0000;
    m_phase  = PH_CMD;
    m_crc    = 16'h0000;
    m_second = 1'b0;
    m_held   = 8'h00;
  endtask

  task automatic predict_reply(input logic [2:0] rq, input logic [7:0] rx,
                               input logic [1:0] ch, input logic [15:0] val,
                               output reply_t r);
    logic [15:0] inv;
    logic [7:0]  b;
    r   = '0;
    inv = ~m_crc;
    case (rq)
      REQ_BUS_RESET: begin
        m_phase  = PH_CMD;
        m_second = 1'b0;
      end
      REQ_MASTER_BYTE: begin
        if (m_phase == PH_CMD) begin
          m_cmd    = rx;
          m_crc    = crc_step(16'h0000, rx);
          m_second = 1'b0;
          m_phase  = PH_ADDR;
        end else if (m_phase == PH_ADDR) begin
          m_crc = crc_step(m_crc, rx);
          if (!m_second) begin
            m_addr   = {8'h00, rx};
            m_second = 1'b1;
          end else begin
            m_addr[15:8] = rx;
            m_second     = 1'b0;
            case (m_cmd)
              CMD_READ:    m_phase = (m_addr < MEMB) ? PH_RD_DATA : PH_DONE;
              CMD_WRITE:   m_phase = (m_addr < MEMB) ? PH_WR_DATA : PH_DONE;
              CMD_CONVERT: m_phase = PH_CV_CRC;
              default: begin
                r.status = ST_UNKNOWN;
                m_phase  = PH_DONE;
              end
            endcase
          end
        end else if (m_phase == PH_WR_DATA) begin
          m_held   = rx;
          m_crc    = crc_step(m_crc, rx);
          m_second = 1'b0;
          m_phase  = PH_WR_CRC;
        end else begin
          r.status = ST_REJECT;
        end
      end
      REQ_READ_SLOT: begin
        case (m_phase)
          PH_RD_DATA: begin
            b          = (m_addr < MEMB) ? m_mem[m_addr] : 8'h00;
            r.tx_valid = 1'b1;
            r.tx_byte  = b;
            m_crc      = crc_step(m_crc, b);
            m_addr     = m_addr + 16'd1;
            if (m_addr % PAGE_BYTES == 0) begin
              m_second = 1'b0;
              m_phase  = PH_RD_CRC;
            end
          end
          PH_RD_CRC, PH_WR_CRC, PH_CV_CRC: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = m_second ? inv[15:8] : inv[7:0];
            if (!m_second) begin
              m_second = 1'b1;
            end else begin
              m_second = 1'b0;
              if (m_phase == PH_RD_CRC) begin
                // every page restarts the crc from zero
                m_crc   = 16'h0000;
                m_phase = (m_addr < MEMB) ? PH_RD_DATA : PH_DONE;
              end else if (m_phase == PH_WR_CRC) begin
                m_phase = PH_WR_ECHO;
              end else begin
                m_phase = PH_CV_BIT;
              end
            end
          end
          PH_WR_ECHO: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = m_held;
            if (m_addr < MEMB && m_addr >= PAGE_BYTES) begin
              m_mem[m_addr] = m_held;
              mask_ctrl_page();
            end
            m_addr  = m_addr + 16'd1;
            m_crc   = m_addr;
            m_phase = (m_addr < MEMB) ? PH_WR_DATA : PH_DONE;
          end
          PH_CV_BIT: begin
            r.tx_valid  = 1'b1;
            r.tx_is_bit = 1'b1;
            m_phase     = PH_DONE;
          end
          default: r.status = ST_REJECT;
        endcase
      end
      REQ_HOST_SET: begin
        if (ch < CHN) begin
          m_mem[2 * ch]     = val[7:0];
          m_mem[2 * ch + 1] = val[15:8];
          mask_ctrl_page();
        end else begin
          r.status = ST_REJECT;
        end
      end
      REQ_HOST_READ: begin
        if (ch < CHN) r.chan_val = {m_mem[2 * ch + 1], m_mem[2 * ch]};
        else r.status = ST_REJECT;
      end
      default: r.status = ST_REJECT;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    n_mismatch++;
    if (n_mismatch <= 100)
      $display("mismatch on response %0d: %s got %h want %h", n_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // one input beat; the sender idles between bursts of random length
  task automatic send_beat(input logic [2:0] rq, input logic [7:0] rx, input logic [1:0] ch,
                           input logic [15:0] val, input bit known, input reply_t want);
    reply_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= rq;
    in_rx_byte  <= rx;
    in_channel  <= ch;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reply(rq, rx, ch, val, r);
    replies_due.push_back(known ? want : r);
    n_items++;
  endtask

  task automatic host_beat();
    send_beat($urandom_range(0, 1) ? REQ_HOST_SET : REQ_HOST_READ, 8'($urandom),
              2'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  // bus beat with unused fields randomized, sometimes preceded by a host access
  task automatic bus_beat(input logic [2:0] rq, input logic [7:0] rx);
    if ($urandom_range(0, 9) == 0) host_beat();
    send_beat(rq, rx, 2'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_transaction();
    int          kind;
    logic [15:0] a;
    logic [7:0]  c;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 7) != 0) bus_beat(REQ_BUS_RESET, 8'($urandom));
    case ($urandom_range(0, 9))
      0:       a = 16'($urandom);
      1:       a = 16'(MEMB - $urandom_range(1, 3));
      default: a = 16'($urandom_range(0, MEMB - 1));
    endcase
    if (kind < 40) begin
      bus_beat(REQ_MASTER_BYTE, CMD_READ);
      bus_beat(REQ_MASTER_BYTE, a[7:0]);
      bus_beat(REQ_MASTER_BYTE, a[15:8]);
      repeat ($urandom_range(1, 20)) bus_beat(REQ_READ_SLOT, 8'($urandom));
    end else if (kind < 72) begin
      bus_beat(REQ_MASTER_BYTE, CMD_WRITE);
      bus_beat(REQ_MASTER_BYTE, a[7:0]);
      bus_beat(REQ_MASTER_BYTE, a[15:8]);
      repeat ($urandom_range(1, 4)) begin
        bus_beat(REQ_MASTER_BYTE, 8'($urandom));
        repeat (3) bus_beat(REQ_READ_SLOT, 8'($urandom));
      end
    end else if (kind < 82) begin
      bus_beat(REQ_MASTER_BYTE, CMD_CONVERT);
      bus_beat(REQ_MASTER_BYTE, a[7:0]);
      bus_beat(REQ_MASTER_BYTE, a[15:8]);
      repeat ($urandom_range(2, 5)) bus_beat(REQ_READ_SLOT, 8'($urandom));
    end else if (kind < 88) begin
      c = 8'($urandom);
      if (c == CMD_READ || c == CMD_WRITE || c == CMD_CONVERT) c = c ^ 8'h01;
      bus_beat(REQ_MASTER_BYTE, c);
      bus_beat(REQ_MASTER_BYTE, a[7:0]);
      bus_beat(REQ_MASTER_BYTE, a[15:8]);
      bus_beat(REQ_READ_SLOT, 8'($urandom));
    end else if (kind < 94) begin
      // broken sequence: read slot where an address byte belongs
      bus_beat(REQ_MASTER_BYTE, $urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
      bus_beat(REQ_MASTER_BYTE, a[7:0]);
      bus_beat(REQ_READ_SLOT, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) bus_beat(3'($urandom_range(0, 7)), 8'($urandom));
    end
  endtask

  // receiver stall pattern, changes mode each time its random timer runs out
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(20, 120);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((stall_timer % 8) < 5);
      endcase
    end
  end

  always @(posedge clk) begin : response_check
    reply_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_checked++;
      if (replies_due.size() == 0) begin
        report_mismatch("response with nothing pending", {8'h00, out_tx_byte}, 16'h0000);
      end else begin
        want = replies_due.pop_front();
        check_field("tx_valid", 16'(out_tx_valid), 16'(want.tx_valid));
        check_field("tx_byte", 16'(out_tx_byte), 16'(want.tx_byte));
        check_field("tx_is_bit", 16'(out_tx_is_bit), 16'(want.tx_is_bit));
        check_field("status", 16'(out_status), 16'(want.status));
        check_field("channel_value", out_channel_value, want.chan_val);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_row(input logic [2:0] rq, input logic [7:0] rx, input logic [1:0] ch,
                         input logic [15:0] val);
    stim_row_t s;
    s.req   = rq;
    s.rx    = rx;
    s.ch    = ch;
    s.val   = val;
    s.known = 1'b0;
    s.want  = '0;
    directed_rows.push_back(s);
  endtask

  task automatic add_known(input logic [2:0] rq, input logic [7:0] rx, input logic [1:0] ch,
                           input logic [15:0] val, input reply_t want);
    stim_row_t s;
    s.req   = rq;
    s.rx    = rx;
    s.ch    = ch;
    s.val   = val;
    s.known = 1'b1;
    s.want  = want;
    directed_rows.push_back(s);
  endtask

  initial begin
    bit drained_mid;
    reply_t ok_beat;
    reply_t rej_beat;
    drained_mid = 1'b0;
    n_mismatch  = 0;
    n_checked   = 0;
    n_items     = 0;
    burst_left  = 0;
    cycle_count = 0;
    stall_mode  = 0;
    stall_timer = 0;
    slave_reset();
    ok_beat  = mk_reply(1'b0, 8'h00, 1'b0, ST_OK, 16'h0000);
    rej_beat = mk_reply(1'b0, 8'h00, 1'b0, ST_REJECT, 16'h0000);

    // host access after reset, extremes of the channel value
    add_known(REQ_HOST_READ, 8'h00, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_HOST_SET, 8'h00, 2'd3, 16'hFFFF, ok_beat);
    add_known(REQ_HOST_READ, 8'hFF, 2'd3, 16'h0000,
              mk_reply(1'b0, 8'h00, 1'b0, ST_OK, 16'hFFFF));
    add_known(3'd7, 8'hFF, 2'd3, 16'hFFFF, rej_beat);
    // read slot while waiting for a command
    add_known(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000, rej_beat);
    add_known(REQ_BUS_RESET, 8'h00, 2'd0, 16'h0000, ok_beat);
    // write the last control byte of page 1, masked on store
    add_known(REQ_MASTER_BYTE, CMD_WRITE, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'h0F, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'h00, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'hFF, 2'd0, 16'h0000, ok_beat);
    add_row(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000);
    add_known(REQ_MASTER_BYTE, 8'h00, 2'd0, 16'h0000, rej_beat);
    add_row(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000);
    add_known(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000,
              mk_reply(1'b1, 8'hFF, 1'b0, ST_OK, 16'h0000));
    add_known(REQ_BUS_RESET, 8'h00, 2'd0, 16'h0000, ok_beat);
    // unknown command, then the transaction is over
    add_known(REQ_MASTER_BYTE, 8'h12, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'h00, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'h80, 2'd0, 16'h0000,
              mk_reply(1'b0, 8'h00, 1'b0, ST_UNKNOWN, 16'h0000));
    add_known(REQ_MASTER_BYTE, 8'h00, 2'd0, 16'h0000, rej_beat);
    add_known(REQ_BUS_RESET, 8'h00, 2'd0, 16'h0000, ok_beat);
    // convert with the address at its top
    add_known(REQ_MASTER_BYTE, CMD_CONVERT, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'hFF, 2'd0, 16'h0000, ok_beat);
    add_known(REQ_MASTER_BYTE, 8'hFF, 2'd0, 16'h0000, ok_beat);
    add_row(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000);
    add_row(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000);
    add_known(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000,
              mk_reply(1'b1, 8'h00, 1'b1, ST_OK, 16'h0000));
    add_known(REQ_READ_SLOT, 8'h00, 2'd0, 16'h0000, rej_beat);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].req, directed_rows[i].rx, directed_rows[i].ch,
                directed_rows[i].val, directed_rows[i].known, directed_rows[i].want);
    drain_replies();

    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      run_transaction();
      if (!drained_mid && n_items >= RAND_ITEMS / 2) begin
        drain_replies();
        drained_mid = 1'b1;
      end
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch("responses still pending", 16'(replies_due.size()), 16'h0000);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
